FILE: design/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants for the LSBI PNG payload extractor.
// ----------------------------------------------------------------------------
package lpe_pkg;

   localparam int unsigned MASK_CARRIERS = 4;
   // smallest image length that holds all mask carriers
   localparam logic [31:0] MASK_MIN_LENGTH = 32'((MASK_CARRIERS / 2) * 3);

   localparam logic [63:0] PNG_SIGNATURE = 64'h89504E470D0A1A0A;
   localparam logic [63:0] IEND_TRAILER  = 64'h49454E44AE426082;

   localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
   localparam logic [1:0] STATUS_IEND    = 2'd1;
   localparam logic [1:0] STATUS_BAD_SIG = 2'd2;
   localparam logic [1:0] STATUS_NO_IEND = 2'd3;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       end_of_image;
   } lpe_req_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [31:0] byte_count;
      logic        last;
   } lpe_rsp_type;

   typedef struct packed {
      logic [1:0]  count;
      lpe_rsp_type first;
      lpe_rsp_type second;
   } lpe_push_type;

   typedef struct packed {
      logic space_ok;
   } lpe_qstat_type;

   function automatic logic [7:0] signature_byte(input logic [2:0] idx);
      logic [5:0] lsb;
      lsb = 6'({3'd7 - idx, 3'd0});
      return PNG_SIGNATURE[lsb +: 8];
   endfunction

endpackage

FILE: design/lpe_core.sv
// ----------------------------------------------------------------------------
// lpe_core
// Per-request extraction: carrier selection, mask capture, bit packing,
// signature check and trailer detection. Emits up to two responses.
// ----------------------------------------------------------------------------
module lpe_core
   import lpe_pkg::*;
#(
   parameter int unsigned PAYLOAD_START = 35
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  lpe_req_type   item,
   input  logic [31:0]   image_length,
   input  lpe_qstat_type qstat,
   output logic          item_taken,
   output lpe_push_type  push
);

   localparam int unsigned CW = $clog2(PAYLOAD_START + 1);

   logic [1:0]    tpos_ff, tpos_in;
   logic [31:0]   tbase_ff, tbase_in;
   logic [CW-1:0] cidx_ff, cidx_in;
   logic [3:0]    mask_ff, mask_in;
   logic [6:0]    shift_ff, shift_in;
   logic [2:0]    bcnt_ff, bcnt_in;
   logic [31:0]   pcount_ff, pcount_in;
   logic [63:0]   window_ff, window_in;
   logic          done_ff, done_in;

   logic          fire, room, is_carrier, bit_val, bad_sig, iend, byte_done;
   logic [7:0]    new_byte;
   logic [63:0]   window_next;
   lpe_rsp_type   r_byte, r_bad, r_iend, r_noend;

   assign fire       = item_valid && qstat.space_ok;
   assign item_taken = fire;

   assign room       = ({1'b0, tbase_ff} + 33'd3) <= {1'b0, image_length};
   assign is_carrier = (tpos_ff != 2'd2) && room;
   assign bit_val    = item.pixel_byte[0] ^ mask_ff[item.pixel_byte[2:1]];
   assign new_byte   = {shift_ff, bit_val};
   assign byte_done  = is_carrier && !done_ff && (cidx_ff == CW'(PAYLOAD_START))
                       && (bcnt_ff == 3'd7);
   assign bad_sig    = (pcount_ff < 32'd8) && (new_byte != signature_byte(pcount_ff[2:0]));
   assign window_next = {window_ff[55:0], new_byte};
   assign iend       = (pcount_ff >= 32'd8) && (window_next == IEND_TRAILER);

   always_comb begin
      r_byte  = '{data_byte: new_byte, status: STATUS_PAYLOAD, byte_count: 32'd0, last: 1'b0};
      r_bad   = '{data_byte: 8'd0, status: STATUS_BAD_SIG, byte_count: 32'd0, last: 1'b1};
      r_iend  = '{data_byte: 8'd0, status: STATUS_IEND, byte_count: pcount_ff + 32'd1,
                  last: 1'b1};
      r_noend = '{data_byte: 8'd0, status: STATUS_NO_IEND, byte_count: 32'd0, last: 1'b1};
   end

   always_comb begin
      tpos_in   = (tpos_ff == 2'd2) ? 2'd0 : tpos_ff + 2'd1;
      tbase_in  = tbase_ff;
      cidx_in   = cidx_ff;
      mask_in   = mask_ff;
      shift_in  = shift_ff;
      bcnt_in   = bcnt_ff;
      pcount_in = pcount_ff;
      window_in = window_ff;
      done_in   = done_ff;
      push      = '{count: 2'd0, first: r_byte, second: r_noend};

      if (tpos_ff == 2'd2 && room) begin
         tbase_in = tbase_ff + 32'd3;
      end

      if (is_carrier) begin
         if (cidx_ff != CW'(PAYLOAD_START)) begin
            cidx_in = cidx_ff + CW'(1);
         end
         if (!done_ff) begin
            if (cidx_ff < CW'(MASK_CARRIERS)) begin
               if (image_length >= MASK_MIN_LENGTH) begin
                  mask_in[cidx_ff[1:0]] = mask_ff[cidx_ff[1:0]] | item.pixel_byte[0];
               end
            end else if (cidx_ff == CW'(PAYLOAD_START)) begin
               if (byte_done) begin
                  shift_in = 7'd0;
                  bcnt_in  = 3'd0;
                  if (bad_sig) begin
                     push.count = 2'd1;
                     push.first = r_bad;
                     done_in    = 1'b1;
                  end else begin
                     pcount_in  = pcount_ff + 32'd1;
                     window_in  = window_next;
                     push.count = 2'd1;
                     if (iend) begin
                        push.count  = 2'd2;
                        push.second = r_iend;
                        done_in     = 1'b1;
                     end
                  end
               end else begin
                  shift_in = new_byte[6:0];
                  bcnt_in  = bcnt_ff + 3'd1;
               end
            end
         end
      end

      if (item.end_of_image) begin
         if (!done_in) begin
            if (push.count == 2'd0) begin
               push.first = r_noend;
            end else begin
               push.second = r_noend;
            end
            push.count = push.count + 2'd1;
         end
         tpos_in   = 2'd0;
         tbase_in  = 32'd0;
         cidx_in   = '0;
         mask_in   = 4'd0;
         shift_in  = 7'd0;
         bcnt_in   = 3'd0;
         pcount_in = 32'd0;
         window_in = 64'd0;
         done_in   = 1'b0;
      end

      if (!fire) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpos_ff   <= 2'd0;
         tbase_ff  <= 32'd0;
         cidx_ff   <= '0;
         mask_ff   <= 4'd0;
         shift_ff  <= 7'd0;
         bcnt_ff   <= 3'd0;
         pcount_ff <= 32'd0;
         window_ff <= 64'd0;
         done_ff   <= 1'b0;
      end else if (fire) begin
         tpos_ff   <= tpos_in;
         tbase_ff  <= tbase_in;
         cidx_ff   <= cidx_in;
         mask_ff   <= mask_in;
         shift_ff  <= shift_in;
         bcnt_ff   <= bcnt_in;
         pcount_ff <= pcount_in;
         window_ff <= window_in;
         done_ff   <= done_in;
      end
   end

endmodule

FILE: design/lpe_out_queue.sv
// ----------------------------------------------------------------------------
// lpe_out_queue
// Four-entry response queue; takes up to two responses per cycle and
// presents the oldest one on the response port.
// ----------------------------------------------------------------------------
module lpe_out_queue
   import lpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lpe_push_type  push,
   output lpe_qstat_type qstat,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output lpe_rsp_type   rsp_payload
);

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QCW    = $clog2(QDEPTH + 1);

   lpe_rsp_type    slot_ff [QDEPTH];
   lpe_rsp_type    slot_in [QDEPTH];
   lpe_rsp_type    shifted [QDEPTH];
   logic [QCW-1:0] count_ff, count_in, base;
   logic           pop;

   assign rsp_valid      = count_ff != '0;
   assign rsp_payload    = slot_ff[0];
   assign pop            = rsp_valid && rsp_ready;
   assign qstat.space_ok = count_ff <= QCW'(QDEPTH - 2);
   assign base           = count_ff - QCW'(pop);
   assign count_in       = base + QCW'(push.count);

   always_comb begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
         shifted[i] = pop ? slot_ff[i + 1] : slot_ff[i];
      end
      shifted[QDEPTH - 1] = slot_ff[QDEPTH - 1];
      for (int i = 0; i < QDEPTH; i++) begin
         slot_in[i] = shifted[i];
         if (push.count != 2'd0 && QCW'(i) == base) begin
            slot_in[i] = push.first;
         end else if (push.count == 2'd2 && QCW'(i) == base + QCW'(1)) begin
            slot_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QDEPTH))
      else $error("response queue overflow");

   a_push_needs_space: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> qstat.space_ok)
      else $error("push into queue without space");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) - QCW'($past(pop))
                                    + QCW'($past(push.count)))
      else $error("queue count out of step with push and pop");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))
      else $error("queue head changed while stalled");

endmodule

FILE: design/lsbi_png_payload_extractor.sv
// ----------------------------------------------------------------------------
// lsbi_png_payload_extractor
// Recovers a PNG payload hidden by LSB inversion in BGR pixel bytes.
// ----------------------------------------------------------------------------
// One pixel-byte request is taken per clock cycle when not stalled. Each
// request is held in an input register and processed from there, pushing
// zero, one or two responses into a four-entry response queue whose oldest
// registered entry is shown on the rsp port. The response port drains one
// response per cycle while rsp_ready is high, so the sustained rate is one
// request per cycle except where a request gives two responses (IEND found,
// or a byte followed by the end-of-image error); requests stall while the
// queue has fewer than two free entries. image_length is written through
// the csr port, which is always ready; the user must write it only while
// the block is idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module lsbi_png_payload_extractor
   import lpe_pkg::*;
#(
   parameter int unsigned PAYLOAD_START = 35
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  lpe_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lpe_rsp_type rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0]   image_length_ff;
   logic          in_valid_ff, in_valid_in;
   lpe_req_type   in_item_ff;
   logic          item_taken;
   lpe_push_type  push;
   lpe_qstat_type qstat;

   assign csr_ready   = 1'b1;
   assign req_ready   = !in_valid_ff || item_taken;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !item_taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_length_ff <= 32'd0;
         in_valid_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            image_length_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
   end

   lpe_core #(
      .PAYLOAD_START (PAYLOAD_START)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (in_valid_ff),
      .item         (in_item_ff),
      .image_length (image_length_ff),
      .qstat        (qstat),
      .item_taken   (item_taken),
      .push         (push)
   );

   lpe_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .qstat       (qstat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
